@@ sv/sitda_pkg.sv @@
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int unsigned ValueW  = 32;
    localparam int unsigned CharW   = 6;
    localparam int unsigned NDigits = 10;
    localparam int unsigned PosW    = 4;
    localparam int unsigned CountW  = 5;

    localparam logic [CharW-1:0] CharZero  = 6'd48;
    localparam logic [CharW-1:0] CharMinus = 6'd45;

    // Ten BCD digits, digit 0 is the units place
    typedef logic [NDigits-1:0][3:0] t_bcd;

    // Controller to datapath commands
    typedef struct packed {
        logic            load;
        logic            shift;
        logic            emit_sign;
        logic            emit_digit;
        logic [PosW-1:0] pos;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic            neg;
        logic [PosW-1:0] msd;
    } t_dp_stat;

endpackage

@@ sv/sitda_dp.sv @@
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude register, shift-and-add-3 BCD converter, output stage.
// ----------------------------------------------------------------------------
module sitda_dp import sitda_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [ValueW-1:0]   i_value,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_valid,
    output logic [CharW-1:0]    o_character,
    output logic                o_last
);

    logic [ValueW-1:0] r_bin, n_bin;
    t_bcd              r_bcd, n_bcd;
    logic              r_neg;
    logic              r_valid;
    logic [CharW-1:0]  r_char;
    logic              r_last;
    t_bcd              adj;
    logic [4*NDigits-1:0] adj_bits;
    logic [PosW-1:0]   msd;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDigits; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
        adj_bits = adj;
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_cmd.load) begin
            n_bin = i_value[ValueW-1] ? (~i_value + 1'b1) : i_value;
            n_bcd = '0;
        end else if (i_cmd.shift) begin
            n_bin = {r_bin[ValueW-2:0], 1'b0};
            n_bcd = {adj_bits[4*NDigits-2:0], r_bin[ValueW-1]};
        end
    end

    // highest nonzero digit; zero value gives the units place
    always_comb begin
        msd = '0;
        for (int i = 0; i < NDigits; i++) begin
            if (r_bcd[i] != 4'd0) msd = PosW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        if (i_cmd.load) r_neg <= i_value[ValueW-1];
        if (i_cmd.emit_sign) begin
            r_char <= CharMinus;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= CharZero + {2'b00, r_bcd[i_cmd.pos]};
            r_last <= (i_cmd.pos == '0);
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_sign | i_cmd.emit_digit;
        end
    end

    assign o_stat.neg   = r_neg;
    assign o_stat.msd   = msd;
    assign o_valid      = r_valid;
    assign o_character  = r_char;
    assign o_last       = r_last;

endmodule

@@ sv/sitda_ctrl.sv @@
// ----------------------------------------------------------------------------
// sitda_ctrl
// Controller: sequences load, 32 conversion shifts and character output.
// ----------------------------------------------------------------------------
module sitda_ctrl import sitda_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIGITS
    } t_state;

    t_state            r_state, n_state;
    logic [CountW-1:0] r_cnt, n_cnt;
    logic [PosW-1:0]   r_pos, n_pos;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        o_cmd   = '0;
        o_cmd.pos = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                n_cnt       = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_SIGN;
            end
            S_SIGN: begin
                o_cmd.emit_sign = i_stat.neg;
                n_pos           = i_stat.msd;
                n_state         = S_DIGITS;
            end
            S_DIGITS: begin
                o_cmd.emit_digit = 1'b1;
                n_pos            = r_pos - 1'b1;
                if (r_pos == '0) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ sv/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, MSD first.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_value and raise start while busy is low; the
//   request is taken at that clock edge and busy rises on the next cycle.
//   Result channel: one character per cycle on o_character, marked by
//   o_valid for exactly one cycle. o_last flags the final character.
//   Negative values begin with '-'; zero gives a single '0'; no leading
//   zeros and no terminator are sent.
// Timing:
//   The magnitude goes through a shift-and-add-3 binary-to-BCD converter,
//   one bit per cycle. The sign state then picks the leading digit (and
//   sends '-' if negative), then digits go out one per cycle. The last
//   character is shown in the first cycle that busy is low.
//   A new request may be given as soon as busy is low.
// Reset: synchronous active-low i_rst_n returns to idle and drops o_valid.
// The receiver cannot stall; every character must be taken when shown.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii import sitda_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ValueW-1:0] i_value,
    output logic              o_valid,
    output logic [CharW-1:0]  o_character,
    output logic              o_last
);

    t_dp_cmd  cmd;   // controller commands
    t_dp_stat stat;  // sign and leading digit position

    sitda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sitda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

@@ dv/signed_int_to_decimal_ascii_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// Self-checking bench for the signed integer to decimal ASCII converter.
// A short table of edge values (zero, one digit, powers of ten, both ends of
// the 32-bit range) runs first, then random requests spread over every text
// length. Each character is checked in order against typed text or a predictor.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test import sitda_pkg::*;;

    localparam int DirN        = 20;
    localparam int RandN       = 130;
    localparam int QuietTail   = 30;   // last random requests go back to back
    localparam int WatchLimit  = 1000; // cycles with no request and no character
    localparam int DrainCycles = 48;   // stray-output window after the last char

    // one expected character of the text stream
    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             last;
    } t_char;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [ValueW-1:0] i_value = '0;
    logic              o_valid;
    logic [CharW-1:0]  o_character;
    logic              o_last;

    // golden text for the request now on the port; empty means "use predictor"
    string             req_text = "";

    t_char             text_q[$];
    int                mismatches    = 0;
    int                requests      = 0;
    int                neg_requests  = 0;
    int                zero_requests = 0;
    int                chars_checked = 0;
    int                idle_cycles   = 0;
    logic [11:0]       lengths_seen  = '0;

    // Directed table: edge values first. Text is typed in where it is obvious.
    logic [ValueW-1:0] dir_value [DirN] = '{
        32'sd0,           32'sd1,           -32'sd1,          32'sd9,
        32'sd10,          -32'sd10,         32'sd99,          32'sd100,
        32'sd12345,       -32'sd98765,      32'sd999999999,   32'sd1000000000,
        -32'sd1000000000, 32'sd2147483647,  -32'sd2147483647, 32'h8000_0000,
        32'h5555_5555,    32'hAAAA_AAAA,    32'sd2147483646,  -32'sd9
    };
    string dir_text [DirN] = '{
        "0",              "1",              "-1",             "9",
        "10",             "",               "",               "",
        "",               "",               "999999999",      "1000000000",
        "-1000000000",    "2147483647",     "-2147483647",    "-2147483648",
        "",               "",               "",               "-9"
    };

    signed_int_to_decimal_ascii i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor: decimal text of a signed 32-bit value. Magnitude is held at
    // 33 bits so the most negative value needs no special handling.
    function automatic void predict_text(input logic [ValueW-1:0] value);
        logic [ValueW:0] mag;
        logic [3:0]      digs [NDigits];
        int              n;
        t_char           c;
        mag = value[ValueW-1] ? ({1'b1, {ValueW{1'b0}}} - {1'b0, value})
                              : {1'b0, value};
        n = 0;
        do begin
            digs[n] = 4'(mag % 33'd10);
            mag     = mag / 33'd10;
            n++;
        end while (mag != 0 && n < NDigits);
        if (value[ValueW-1]) begin
            c.ch   = CharMinus;
            c.last = 1'b0;
            text_q.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.ch   = CharZero + CharW'(digs[k]);
            c.last = (k == 0);
            text_q.push_back(c);
        end
    endfunction

    // Request side: optional idle burst, then hold start until the request is
    // taken. A late gap waits for busy to drop first, so the idle cycles land
    // on the tail of the previous text instead of inside the conversion.
    task automatic issue_request(input logic [ValueW-1:0] value, input string text,
                                 input int gap, input bit late);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            if (late) begin
                while (busy) @(negedge i_clk);
            end
            repeat (gap) @(negedge i_clk);
        end
        start    <= 1'b1;
        i_value  <= value;
        req_text  = text;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Hold the request side off until every expected character is back.
    task automatic drain_text;
        @(negedge i_clk);
        start <= 1'b0;
        while (text_q.size() != 0) @(negedge i_clk);
    endtask

    // Monitor: queue up the text of each accepted request, then check any
    // character shown this cycle. Both happen in one block so the order of
    // push and pop is fixed.
    always @(posedge i_clk) begin : monitor
        t_char exp_c;
        t_char c;
        byte   b;
        int    n0;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end

            if (start && !busy) begin
                n0 = text_q.size();
                if (req_text.len() != 0) begin
                    for (int i = 0; i < req_text.len(); i++) begin
                        b      = req_text[i];
                        c.ch   = b[CharW-1:0];
                        c.last = (i == req_text.len() - 1);
                        text_q.push_back(c);
                    end
                end else begin
                    predict_text(i_value);
                end
                lengths_seen[text_q.size() - n0] = 1'b1;
                requests++;
                if (i_value[ValueW-1]) neg_requests++;
                if (i_value == '0) zero_requests++;
            end

            if (o_valid) begin
                if (text_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected char 0x%02h last=%0b, nothing pending",
                                 $time, o_character, o_last);
                    end
                    mismatches++;
                end else begin
                    exp_c = text_q.pop_front();
                    chars_checked++;
                    if (o_character !== exp_c.ch || o_last !== exp_c.last) begin
                        if (mismatches < 10) begin
                            $display("%0t: char mismatch exp 0x%02h last=%0b, got 0x%02h last=%0b",
                                     $time, exp_c.ch, exp_c.last, o_character, o_last);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: too long with no request taken and no character shown.
    initial begin : watchdog
        @(negedge i_clk);
        while (idle_cycles < WatchLimit) @(negedge i_clk);
        $display("%0t: timeout, %0d chars still pending", $time, text_q.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [ValueW-1:0] v;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   p;
        int                d;
        int                gap;
        bit                quiet;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < DirN; i++) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
            issue_request(dir_value[i], dir_text[i], gap, $urandom_range(0, 1));
        end

        // Sender pause: let the whole directed set come back before going random
        drain_text();

        // Random requests, mixed so that every text length turns up often
        for (int i = 0; i < RandN; i++) begin
            if (i == RandN / 2) drain_text();
            case ($urandom_range(0, 5))
                0, 5: v = $urandom();
                1: begin
                    v = $urandom_range(0, 20);
                    if ($urandom_range(0, 1)) v = -v;
                end
                2: begin
                    // uniform over one chosen digit count
                    d  = $urandom_range(1, NDigits);
                    lo = 1;
                    repeat (d - 1) lo = lo * 10;
                    hi = lo * 10 - 1;
                    if (d == 1) lo = 0;
                    if (hi > 64'd2147483647) hi = 64'd2147483647;
                    p  = {$urandom(), $urandom()};
                    v  = ValueW'(lo + p % (hi - lo + 1));
                    if ($urandom_range(0, 1)) v = -v;
                end
                3: begin
                    // around a power of ten, where the digit count steps
                    p = 1;
                    repeat ($urandom_range(0, 9)) p = p * 10;
                    v = ValueW'(p) + ValueW'($urandom_range(0, 2)) - 32'd1;
                    if ($urandom_range(0, 1)) v = -v;
                end
                default: begin
                    v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                             : 32'h7FFF_FFFF - $urandom_range(0, 3);
                end
            endcase
            quiet = (i >= RandN - QuietTail) || (i >= 40 && i < 55);
            gap   = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
            issue_request(v, "", gap, $urandom_range(0, 1));
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (text_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (text_q.size() != 0) begin
            $display("%0d expected chars never arrived", text_q.size());
            mismatches++;
        end
        if (mismatches > 10) $display("%0d mismatches in total", mismatches);
        $display("Converted %0d values (%0d negative, %0d zero), %0d chars checked.",
                 requests, neg_requests, zero_requests, chars_checked);
        $display("Text lengths exercised: %0d of 11 possible.", $countones(lengths_seen));
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/sitda_pkg.sv
sv/sitda_dp.sv
sv/sitda_ctrl.sv
sv/signed_int_to_decimal_ascii.sv
dv/signed_int_to_decimal_ascii_test.sv
